/* rtl/core/ugic_pkg.sv */
package ugic_pkg;

    // Fixed-point constants (angles Q3.13, CORDIC accumulator in units of 2^-16 rad).
    localparam logic signed [16:0] PI_Q13      = 17'sd25736;
    localparam logic signed [16:0] TWO_PI_Q13  = 17'sd51472;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [32:0]        DEAD_POS    = 33'd3277;
    localparam logic signed [15:0] DEAD_ANG    = 16'sd410;
    localparam logic [16:0]        ONE_Q8      = 17'd256;

    // CORDIC sizing.
    localparam int CW            = 46;
    localparam int ZW            = 20;
    localparam int CORDIC_STEPS  = 17;
    localparam logic [CW-1:0] MAG_TARGET = 46'h0100_0000_0000;
    localparam logic [CW-1:0] MAG_COARSE = 46'h0001_0000_0000;

    // Divider and square root sizing.
    localparam int DIV_BITS  = 52;
    localparam int SQRT_ITER = 32;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_STIFFNESS,
        REG_DAMPING,
        REG_MASS,
        REG_MAX_LIN,
        REG_MAX_ANG,
        REG_GOAL_X,
        REG_GOAL_Y,
        REG_GOAL_HDG
    } reg_idx_t;

    // Main sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_WZ,
        ST_MUL_ZZ,
        ST_YAW_GO,
        ST_YAW_WAIT,
        ST_BRG_GO,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_SUM,
        ST_SQRT,
        ST_BRG_WAIT,
        ST_ERR,
        ST_MUL_K,
        ST_MUL_B,
        ST_NUM,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } ugic_state_t;

    // CORDIC sequencer states.
    typedef enum logic [1:0] {
        C_IDLE,
        C_SCALE,
        C_ITER,
        C_FIN
    } cordic_state_t;

    // Request to the atan2 unit.
    typedef struct packed {
        logic               start;
        logic signed [33:0] y;
        logic signed [33:0] x;
    } cordic_req_t;

    // Status from the atan2 unit.
    typedef struct packed {
        logic               busy;
        logic signed [15:0] angle;
    } cordic_rsp_t;

    // Arctangent table in units of 2^-16 rad.
    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30386;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/ugic_odo_if.sv */
interface ugic_odo_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [23:0] lin_speed;
    logic signed [23:0] ang_speed;

    modport source (
        output valid, pos_x, pos_y, quat_z, quat_w, lin_speed, ang_speed,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, quat_z, quat_w, lin_speed, ang_speed,
        output ready
    );
endinterface

/* rtl/core/ugic_cmd_if.sv */
interface ugic_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] lin_cmd;
    logic signed [23:0] ang_cmd;
    logic               goal_reached;

    modport source (
        output valid, lin_cmd, ang_cmd, goal_reached,
        input  ready
    );
    modport sink (
        input  valid, lin_cmd, ang_cmd, goal_reached,
        output ready
    );
endinterface

/* rtl/core/ugic_cordic.sv */
module ugic_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ugic_pkg::cordic_req_t req,
    output ugic_pkg::cordic_rsp_t rsp
);

    ugic_pkg::cordic_state_t state_reg, state_next;

    logic signed [ugic_pkg::CW-1:0] x_reg, y_reg;
    logic signed [ugic_pkg::ZW-1:0] z_reg;
    logic [4:0]                     i_reg;
    logic signed [15:0]             ang_reg;

    logic signed [ugic_pkg::CW-1:0] xi, yi, xr, yr;
    logic signed [ugic_pkg::ZW-1:0] zr;
    logic                           is_zero;
    logic [ugic_pkg::CW-1:0]        xa, ya, mag;
    logic                           mag_ok, mag_coarse;
    logic signed [ugic_pkg::CW-1:0] sx, sy;
    logic signed [ugic_pkg::ZW-1:0] zs, zq;
    logic signed [15:0]             ang_clamped;

    // Rotate a left half plane vector by a quarter turn.
    always_comb
    begin
        xi = {{(ugic_pkg::CW-34){req.x[33]}}, req.x};
        yi = {{(ugic_pkg::CW-34){req.y[33]}}, req.y};
        is_zero = (req.x == 34'sd0) && (req.y == 34'sd0);
        xr = xi;
        yr = yi;
        zr = '0;
        if (xi < 0)
        begin
            if (yi >= 0)
            begin
                xr = yi;
                yr = -xi;
                zr = ugic_pkg::HALF_PI_Q16;
            end
            else
            begin
                xr = -yi;
                yr = xi;
                zr = -ugic_pkg::HALF_PI_Q16;
            end
        end
    end

    // Normalize check, one vectoring step and the rounded, clamped angle.
    always_comb
    begin
        xa = x_reg[ugic_pkg::CW-1] ? ugic_pkg::CW'(-x_reg) : ugic_pkg::CW'(x_reg);
        ya = y_reg[ugic_pkg::CW-1] ? ugic_pkg::CW'(-y_reg) : ugic_pkg::CW'(y_reg);
        mag = (xa > ya) ? xa : ya;
        mag_ok = (mag >= ugic_pkg::MAG_TARGET);
        mag_coarse = (mag < ugic_pkg::MAG_COARSE);
        sx = y_reg >>> i_reg;
        sy = x_reg >>> i_reg;
        zs = z_reg + 20'sd4;
        zq = zs >>> 3;
        if (zq > 20'(ugic_pkg::PI_Q13))
            ang_clamped = 16'(ugic_pkg::PI_Q13);
        else if (zq < -20'(ugic_pkg::PI_Q13))
            ang_clamped = -16'(ugic_pkg::PI_Q13);
        else
            ang_clamped = 16'(zq);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ugic_pkg::C_IDLE:
            begin
                if (req.start)
                    state_next = is_zero ? ugic_pkg::C_FIN : ugic_pkg::C_SCALE;
            end
            ugic_pkg::C_SCALE:
            begin
                if (mag_ok)
                    state_next = ugic_pkg::C_ITER;
            end
            ugic_pkg::C_ITER:
            begin
                if (i_reg == 5'(ugic_pkg::CORDIC_STEPS - 1))
                    state_next = ugic_pkg::C_FIN;
            end
            ugic_pkg::C_FIN:  state_next = ugic_pkg::C_IDLE;
            default:          state_next = ugic_pkg::C_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        rsp.busy  = (state_reg != ugic_pkg::C_IDLE);
        rsp.angle = ang_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ugic_pkg::C_IDLE;
        else
            state_reg <= state_next;
    end

    // Vector, angle accumulator, step count and output angle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ugic_pkg::C_IDLE:
            begin
                if (req.start)
                begin
                    x_reg <= xr;
                    y_reg <= yr;
                    z_reg <= is_zero ? '0 : zr;
                    i_reg <= '0;
                end
            end
            ugic_pkg::C_SCALE:
            begin
                if (!mag_ok)
                begin
                    if (mag_coarse)
                    begin
                        x_reg <= x_reg <<< 8;
                        y_reg <= y_reg <<< 8;
                    end
                    else
                    begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end
                end
            end
            ugic_pkg::C_ITER:
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + sx;
                    y_reg <= y_reg - sy;
                    z_reg <= z_reg + ugic_pkg::atan_tab(i_reg);
                end
                else
                begin
                    x_reg <= x_reg - sx;
                    y_reg <= y_reg + sy;
                    z_reg <= z_reg - ugic_pkg::atan_tab(i_reg);
                end
                i_reg <= i_reg + 5'd1;
            end
            ugic_pkg::C_FIN:  ang_reg <= ang_clamped;
            default:          ang_reg <= ang_reg;
        endcase
    end

endmodule

/* rtl/core/unicycle_goal_impedance_controller.sv */
// Go-to-goal controller for a unicycle robot with a spring-damper drive law. Each odometry
// word (position, yaw quaternion z/w, measured speeds) yields one command word (linear and
// angular speed, goal-reached flag), except the first word after reset, which only primes
// the block. One shared CORDIC unit resolves the yaw and then the bearing (a scaling phase
// plus 17 steps each), a bit-per-cycle square root gives the distance, and a restoring
// divider serves each of the two commands; a single 34x34 multiplier is reused for every
// product. Each command that needs no division (no forward drive because the heading error
// is 90 degrees or more, or inside the dead zone, the linear command, and the angular
// command once the goal is reached) skips the divider. The odometry side is ready only
// while the sequencer is idle; a finished command waits in an output register so the next
// odometry word can be accepted meanwhile. Configuration is written over the APB port at
// byte address 4*index and must only be written while the block is idle.
module unicycle_goal_impedance_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ugic_odo_if.sink    odo,
    ugic_cmd_if.source  cmd
);

    ugic_pkg::ugic_state_t state_reg, state_next;
    logic                  primed_reg;

    // Configuration registers.
    logic [15:0]        stiff_reg, damp_reg, mass_reg;
    logic [22:0]        maxlin_reg, maxang_reg;
    logic signed [31:0] goalx_reg, goaly_reg;
    logic signed [15:0] goalhdg_reg;

    // Captured odometry word.
    logic signed [15:0] qz_reg, qw_reg;
    logic signed [23:0] v_reg, w_reg;
    logic signed [32:0] dx_reg, dy_reg;

    // Shared multiplier.
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg, acc_reg;

    // Angles and distance.
    logic signed [33:0] yq_reg;
    logic signed [15:0] yaw_reg, brg_reg, herr_reg, terr_reg;
    logic [32:0]        dist_reg;
    logic               dead_reg;

    // Square root.
    logic [62:0] sq_n_reg;
    logic [63:0] root_reg;
    logic [4:0]  sq_cnt_reg;

    // Divider.
    logic        pass_reg;
    logic [ugic_pkg::DIV_BITS-1:0] dvd_reg;
    logic [16:0] rem_reg, den_reg;
    logic        neg_reg;
    logic [5:0]  div_cnt_reg;

    // Results.
    logic signed [23:0] lin_reg, ang_reg;
    logic               reached_reg;
    logic               out_valid_reg;
    logic signed [23:0] out_lin_reg, out_ang_reg;
    logic               out_reached_reg;

    ugic_pkg::cordic_req_t creq;
    ugic_pkg::cordic_rsp_t crsp;

    logic        odo_acc, cfg_wr, out_load;
    logic [32:0] ax, ay;
    logic        huge;
    logic [30:0] ax_h, ay_h;
    logic [63:0] sq_bit, sq_trial;
    logic        sq_take;
    logic [32:0] dist_c;
    logic signed [16:0] herr_raw, terr_raw;
    logic signed [15:0] herr_c, terr_c;
    logic signed [15:0] herr_abs, terr_abs;
    logic signed [67:0] num;
    logic [67:0]        num_mag;
    logic [16:0]        den_c;
    logic [17:0]        rem_sh;
    logic               q_bit;
    logic [22:0]        lim, q_sat;
    logic signed [23:0] q_signed;
    logic               skip_ang, skip_lin;

    ugic_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (ugic_pkg::reg_idx_t'(paddr[4:2]))
            ugic_pkg::REG_STIFFNESS: prdata = {16'd0, stiff_reg};
            ugic_pkg::REG_DAMPING:   prdata = {16'd0, damp_reg};
            ugic_pkg::REG_MASS:      prdata = {16'd0, mass_reg};
            ugic_pkg::REG_MAX_LIN:   prdata = {9'd0, maxlin_reg};
            ugic_pkg::REG_MAX_ANG:   prdata = {9'd0, maxang_reg};
            ugic_pkg::REG_GOAL_X:    prdata = goalx_reg;
            ugic_pkg::REG_GOAL_Y:    prdata = goaly_reg;
            ugic_pkg::REG_GOAL_HDG:  prdata = {16'd0, goalhdg_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg   <= 16'd256;
            damp_reg    <= 16'd205;
            mass_reg    <= 16'd26;
            maxlin_reg  <= 23'd32768;
            maxang_reg  <= 23'd65536;
            goalx_reg   <= 32'sd0;
            goaly_reg   <= 32'sd0;
            goalhdg_reg <= 16'sd0;
        end
        else if (cfg_wr)
        begin
            case (ugic_pkg::reg_idx_t'(paddr[4:2]))
                ugic_pkg::REG_STIFFNESS: stiff_reg   <= pwdata[15:0];
                ugic_pkg::REG_DAMPING:   damp_reg    <= pwdata[15:0];
                ugic_pkg::REG_MASS:      mass_reg    <= pwdata[15:0];
                ugic_pkg::REG_MAX_LIN:   maxlin_reg  <= pwdata[22:0];
                ugic_pkg::REG_MAX_ANG:   maxang_reg  <= pwdata[22:0];
                ugic_pkg::REG_GOAL_X:    goalx_reg   <= pwdata;
                ugic_pkg::REG_GOAL_Y:    goaly_reg   <= pwdata;
                ugic_pkg::REG_GOAL_HDG:  goalhdg_reg <= pwdata[15:0];
                default:                 stiff_reg   <= stiff_reg;
            endcase
        end
    end

    // Distance operands, halved when either offset is too large for the square.
    always_comb
    begin
        ax   = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ay   = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        huge = ax[32] || ax[31] || ay[32] || ay[31];
        ax_h = huge ? ax[31:1] : ax[30:0];
        ay_h = huge ? ay[31:1] : ay[30:0];
    end

    // Square root step.
    always_comb
    begin
        sq_bit   = 64'h4000_0000_0000_0000 >> {sq_cnt_reg, 1'b0};
        sq_trial = root_reg + sq_bit;
        sq_take  = ({1'b0, sq_n_reg} >= sq_trial);
        dist_c   = huge ? {root_reg[31:0], 1'b0} : {1'b0, root_reg[31:0]};
    end

    // Heading errors wrapped to plus or minus pi.
    always_comb
    begin
        herr_raw = 17'(brg_reg) - 17'(yaw_reg);
        terr_raw = 17'(goalhdg_reg) - 17'(yaw_reg);
        if (herr_raw > ugic_pkg::PI_Q13)
            herr_c = 16'(herr_raw - ugic_pkg::TWO_PI_Q13);
        else if (herr_raw < -ugic_pkg::PI_Q13)
            herr_c = 16'(herr_raw + ugic_pkg::TWO_PI_Q13);
        else
            herr_c = 16'(herr_raw);
        if (terr_raw > ugic_pkg::PI_Q13)
            terr_c = 16'(terr_raw - ugic_pkg::TWO_PI_Q13);
        else if (terr_raw < -ugic_pkg::PI_Q13)
            terr_c = 16'(terr_raw + ugic_pkg::TWO_PI_Q13);
        else
            terr_c = 16'(terr_raw);
        herr_abs = herr_reg[15] ? -herr_reg : herr_reg;
        terr_abs = terr_reg[15] ? -terr_reg : terr_reg;
    end

    // Drive numerator, divisor, skip conditions, divider step and clamp.
    always_comb
    begin
        num      = acc_reg - prod_reg;
        num_mag  = num[67] ? 68'(-num) : 68'(num);
        den_c    = (!pass_reg && dead_reg) ? ugic_pkg::ONE_Q8
                                           : 17'(mass_reg) + ugic_pkg::ONE_Q8;
        skip_ang = dead_reg && (terr_abs < ugic_pkg::DEAD_ANG);
        skip_lin = dead_reg || (herr_abs >= ugic_pkg::HALF_PI_Q13);
        rem_sh   = {rem_reg, dvd_reg[ugic_pkg::DIV_BITS-1]};
        q_bit    = (rem_sh >= {1'b0, den_reg});
        lim      = pass_reg ? maxlin_reg : maxang_reg;
        q_sat    = (dvd_reg > ugic_pkg::DIV_BITS'(lim)) ? lim : dvd_reg[22:0];
        q_signed = neg_reg ? -{1'b0, q_sat} : {1'b0, q_sat};
    end

    assign odo_acc  = odo.valid && odo.ready;
    assign out_load = (state_reg == ugic_pkg::ST_DONE) && (!out_valid_reg || cmd.ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ugic_pkg::ST_IDLE:
            begin
                if (odo_acc && primed_reg)
                    state_next = ugic_pkg::ST_MUL_WZ;
            end
            ugic_pkg::ST_MUL_WZ:   state_next = ugic_pkg::ST_MUL_ZZ;
            ugic_pkg::ST_MUL_ZZ:   state_next = ugic_pkg::ST_YAW_GO;
            ugic_pkg::ST_YAW_GO:   state_next = ugic_pkg::ST_YAW_WAIT;
            ugic_pkg::ST_YAW_WAIT:
            begin
                if (!crsp.busy)
                    state_next = ugic_pkg::ST_BRG_GO;
            end
            ugic_pkg::ST_BRG_GO:   state_next = ugic_pkg::ST_SQ_X;
            ugic_pkg::ST_SQ_X:     state_next = ugic_pkg::ST_SQ_Y;
            ugic_pkg::ST_SQ_Y:     state_next = ugic_pkg::ST_SQ_SUM;
            ugic_pkg::ST_SQ_SUM:   state_next = ugic_pkg::ST_SQRT;
            ugic_pkg::ST_SQRT:
            begin
                if (sq_cnt_reg == 5'(ugic_pkg::SQRT_ITER - 1))
                    state_next = ugic_pkg::ST_BRG_WAIT;
            end
            ugic_pkg::ST_BRG_WAIT:
            begin
                if (!crsp.busy)
                    state_next = ugic_pkg::ST_ERR;
            end
            ugic_pkg::ST_ERR:      state_next = ugic_pkg::ST_MUL_K;
            ugic_pkg::ST_MUL_K:    state_next = ugic_pkg::ST_MUL_B;
            ugic_pkg::ST_MUL_B:    state_next = ugic_pkg::ST_NUM;
            ugic_pkg::ST_NUM:
            begin
                if (!pass_reg && skip_ang)
                    state_next = ugic_pkg::ST_MUL_K;
                else if (pass_reg && skip_lin)
                    state_next = ugic_pkg::ST_DONE;
                else
                    state_next = ugic_pkg::ST_DIV;
            end
            ugic_pkg::ST_DIV:
            begin
                if (div_cnt_reg == 6'(ugic_pkg::DIV_BITS - 1))
                    state_next = ugic_pkg::ST_STORE;
            end
            ugic_pkg::ST_STORE:
                state_next = pass_reg ? ugic_pkg::ST_DONE : ugic_pkg::ST_MUL_K;
            ugic_pkg::ST_DONE:
            begin
                if (out_load)
                    state_next = ugic_pkg::ST_IDLE;
            end
            default:               state_next = ugic_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, CORDIC request and multiplier operands.
    always_comb
    begin
        odo.ready  = (state_reg == ugic_pkg::ST_IDLE);
        creq.start = 1'b0;
        creq.y     = {dy_reg[32], dy_reg};
        creq.x     = {dx_reg[32], dx_reg};
        mul_a      = 34'sd0;
        mul_b      = 34'sd0;
        case (state_reg)
            ugic_pkg::ST_MUL_WZ:
            begin
                mul_a = 34'(qw_reg);
                mul_b = 34'(qz_reg);
            end
            ugic_pkg::ST_MUL_ZZ:
            begin
                mul_a = 34'(qz_reg);
                mul_b = 34'(qz_reg);
            end
            ugic_pkg::ST_YAW_GO:
            begin
                creq.start = 1'b1;
                creq.y     = yq_reg;
                creq.x     = 34'sd1073741824 - $signed({prod_reg[32:0], 1'b0});
            end
            ugic_pkg::ST_BRG_GO:   creq.start = 1'b1;
            ugic_pkg::ST_SQ_X:
            begin
                mul_a = $signed({3'b0, ax_h});
                mul_b = $signed({3'b0, ax_h});
            end
            ugic_pkg::ST_SQ_Y:
            begin
                mul_a = $signed({3'b0, ay_h});
                mul_b = $signed({3'b0, ay_h});
            end
            ugic_pkg::ST_MUL_K:
            begin
                mul_a = $signed({18'b0, stiff_reg});
                if (pass_reg)
                    mul_b = $signed({1'b0, dist_reg});
                else
                    mul_b = dead_reg ? 34'(terr_reg) : 34'(herr_reg);
            end
            ugic_pkg::ST_MUL_B:
            begin
                mul_a = $signed({18'b0, damp_reg});
                mul_b = pass_reg ? 34'(v_reg) : 34'(w_reg);
            end
            default:               mul_a = 34'sd0;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ugic_pkg::ST_IDLE;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (odo_acc)
                primed_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (cmd.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ugic_pkg::ST_IDLE:
            begin
                if (odo_acc)
                begin
                    qz_reg <= odo.quat_z;
                    qw_reg <= odo.quat_w;
                    v_reg  <= odo.lin_speed;
                    w_reg  <= odo.ang_speed;
                    dx_reg <= 33'(goalx_reg) - 33'(odo.pos_x);
                    dy_reg <= 33'(goaly_reg) - 33'(odo.pos_y);
                end
            end
            ugic_pkg::ST_MUL_ZZ:   yq_reg <= $signed({prod_reg[32:0], 1'b0});
            ugic_pkg::ST_YAW_WAIT: yaw_reg <= crsp.angle;
            ugic_pkg::ST_SQ_Y:     acc_reg <= prod_reg;
            ugic_pkg::ST_SQ_SUM:
            begin
                sq_n_reg   <= 63'(acc_reg + prod_reg);
                root_reg   <= 64'd0;
                sq_cnt_reg <= 5'd0;
            end
            ugic_pkg::ST_SQRT:
            begin
                if (sq_take)
                begin
                    sq_n_reg <= sq_n_reg - sq_trial[62:0];
                    root_reg <= (root_reg >> 1) + sq_bit;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
            end
            ugic_pkg::ST_BRG_WAIT: brg_reg <= crsp.angle;
            ugic_pkg::ST_ERR:
            begin
                herr_reg    <= herr_c;
                terr_reg    <= terr_c;
                dist_reg    <= dist_c;
                dead_reg    <= (dist_c < ugic_pkg::DEAD_POS);
                pass_reg    <= 1'b0;
                reached_reg <= 1'b0;
            end
            ugic_pkg::ST_MUL_B:    acc_reg <= pass_reg ? prod_reg : (prod_reg <<< 3);
            ugic_pkg::ST_NUM:
            begin
                if (!pass_reg && skip_ang)
                begin
                    ang_reg     <= 24'sd0;
                    reached_reg <= 1'b1;
                    pass_reg    <= 1'b1;
                end
                else if (pass_reg && skip_lin)
                begin
                    lin_reg <= 24'sd0;
                end
                else
                begin
                    dvd_reg     <= ugic_pkg::DIV_BITS'(num_mag)
                                   + ugic_pkg::DIV_BITS'(den_c >> 1);
                    den_reg     <= den_c;
                    neg_reg     <= num[67];
                    rem_reg     <= 17'd0;
                    div_cnt_reg <= 6'd0;
                end
            end
            ugic_pkg::ST_DIV:
            begin
                rem_reg     <= q_bit ? 17'(rem_sh - {1'b0, den_reg}) : rem_sh[16:0];
                dvd_reg     <= {dvd_reg[ugic_pkg::DIV_BITS-2:0], q_bit};
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
            ugic_pkg::ST_STORE:
            begin
                if (pass_reg)
                    lin_reg <= q_signed;
                else
                begin
                    ang_reg  <= q_signed;
                    pass_reg <= 1'b1;
                end
            end
            ugic_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_lin_reg     <= lin_reg;
                    out_ang_reg     <= ang_reg;
                    out_reached_reg <= reached_reg;
                end
            end
            default:               acc_reg <= acc_reg;
        endcase
    end

    // Command word.
    assign cmd.valid        = out_valid_reg;
    assign cmd.lin_cmd      = out_lin_reg;
    assign cmd.ang_cmd      = out_ang_reg;
    assign cmd.goal_reached = out_reached_reg;

endmodule

/* test/ugic_cmd_checker.sv */
module ugic_cmd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    ugic_odo_if         odo,
    ugic_cmd_if         cmd,
    output int          outstanding,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ANG_PI      = 25736;
    localparam longint ANG_TWO_PI  = 51472;
    localparam longint ANG_HALF_PI = 12868;
    localparam longint BRG_HALF_PI = 102944;
    localparam longint POS_DEAD    = 3277;
    localparam longint HDG_DEAD    = 410;
    localparam longint GAIN_ONE    = 256;
    localparam longint ANGLE_STEP [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                           512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    typedef struct {
        logic signed [23:0] lin;
        logic signed [23:0] ang;
        logic               reached;
    } cmd_word_t;

    // Shadow copy of the control registers and the priming flag.
    logic [15:0]        k_gain, b_gain, mass;
    logic [22:0]        lin_limit, ang_limit;
    logic signed [31:0] tgt_x, tgt_y;
    logic signed [15:0] tgt_hdg;
    logic               seen_first;

    cmd_word_t expected_cmds[$];

    assign outstanding = expected_cmds.size();

    // Vectoring CORDIC arctangent, result in Q3.13.
    function automatic longint arctan_q13(longint y, longint x);
        longint z, t, mag, sx, sy, r;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = BRG_HALF_PI;
            end
            else
            begin
                x = -y; y = t; z = -BRG_HALF_PI;
            end
        end
        mag = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        while (mag < (64'sd1 <<< 40))
        begin
            x = x * 2; y = y * 2; mag = mag * 2;
        end
        for (int i = 0; i < 17; i++)
        begin
            sx = y >>> i;
            sy = x >>> i;
            if (y >= 0)
            begin
                x = x + sx; y = y - sy; z = z + ANGLE_STEP[i];
            end
            else
            begin
                x = x - sx; y = y + sy; z = z - ANGLE_STEP[i];
            end
        end
        r = (z + 4) >>> 3;
        if (r > ANG_PI) r = ANG_PI;
        if (r < -ANG_PI) r = -ANG_PI;
        return r;
    endfunction

    function automatic longint wrap_pi(longint a);
        while (a > ANG_PI) a -= ANG_TWO_PI;
        while (a < -ANG_PI) a += ANG_TWO_PI;
        return a;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Division rounded to nearest, halves away from zero.
    function automatic longint round_div(longint num, longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint limit_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Controller law for one odometry word; returns 0 when no command follows.
    function automatic bit controller_law(output cmd_word_t res);
        longint px, py, qz, qw, v, w, k, b, den, yaw, dx, dy, range_q16, brg, herr, terr;
        longint lin, ang;
        longint unsigned ax, ay;
        px = longint'(odo.pos_x); py = longint'(odo.pos_y);
        qz = longint'(odo.quat_z); qw = longint'(odo.quat_w);
        v = longint'(odo.lin_speed); w = longint'(odo.ang_speed);
        k = longint'(k_gain); b = longint'(b_gain); den = longint'(mass) + GAIN_ONE;
        res.lin = '0; res.ang = '0; res.reached = 1'b0;
        yaw = arctan_q13(2 * qw * qz, (64'sd1 <<< 30) - 2 * qz * qz);
        if (!seen_first)
        begin
            seen_first = 1'b1;
            return 1'b0;
        end
        dx = longint'(tgt_x) - px;
        dy = longint'(tgt_y) - py;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        // Very long distances are halved so the squares stay in range.
        if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31))
        begin
            ax = ax >> 1; ay = ay >> 1;
            range_q16 = floor_sqrt(ax * ax + ay * ay) << 1;
        end
        else
            range_q16 = floor_sqrt(ax * ax + ay * ay);
        brg = arctan_q13(dy, dx);
        herr = wrap_pi(brg - yaw);
        terr = wrap_pi(longint'(tgt_hdg) - yaw);
        lin = 0;
        if ((herr < 0 ? -herr : herr) < ANG_HALF_PI)
            lin = round_div(k * range_q16 - b * v, den);
        ang = round_div(k * herr * 8 - b * w, den);
        lin = limit_mag(lin, longint'(lin_limit));
        ang = limit_mag(ang, longint'(ang_limit));
        // Dead zone: turn in place toward the goal heading, or stop.
        if (range_q16 < POS_DEAD)
        begin
            lin = 0;
            ang = limit_mag(round_div(k * terr * 8 - b * w, GAIN_ONE), longint'(ang_limit));
            if ((terr < 0 ? -terr : terr) < HDG_DEAD)
            begin
                ang = 0;
                res.reached = 1'b1;
            end
        end
        res.lin = lin[23:0];
        res.ang = ang[23:0];
        return 1'b1;
    endfunction

    // Track register writes, predict each accepted word and check each command.
    always @(posedge clk or negedge rst_n)
    begin
        cmd_word_t pred, got;
        if (!rst_n)
        begin
            k_gain = 16'd256; b_gain = 16'd205; mass = 16'd26;
            lin_limit = 23'd32768; ang_limit = 23'd65536;
            tgt_x = '0; tgt_y = '0; tgt_hdg = '0;
            seen_first = 1'b0;
            errors = 0;
            expected_cmds.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (ugic_pkg::reg_idx_t'(paddr[4:2]))
                    ugic_pkg::REG_STIFFNESS: k_gain = pwdata[15:0];
                    ugic_pkg::REG_DAMPING:   b_gain = pwdata[15:0];
                    ugic_pkg::REG_MASS:      mass = pwdata[15:0];
                    ugic_pkg::REG_MAX_LIN:   lin_limit = pwdata[22:0];
                    ugic_pkg::REG_MAX_ANG:   ang_limit = pwdata[22:0];
                    ugic_pkg::REG_GOAL_X:    tgt_x = pwdata;
                    ugic_pkg::REG_GOAL_Y:    tgt_y = pwdata;
                    ugic_pkg::REG_GOAL_HDG:  tgt_hdg = pwdata[15:0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready)
            begin
                got.lin = cmd.lin_cmd; got.ang = cmd.ang_cmd; got.reached = cmd.goal_reached;
                if (expected_cmds.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected command word lin=%0d ang=%0d reached=%0b",
                             $realtime, got.lin, got.ang, got.reached);
                end
                else
                begin
                    pred = expected_cmds.pop_front();
                    if (got.lin !== pred.lin)
                    begin
                        errors++;
                        $display("%0t: lin_cmd expected %0d actual %0d",
                                 $realtime, pred.lin, got.lin);
                    end
                    if (got.ang !== pred.ang)
                    begin
                        errors++;
                        $display("%0t: ang_cmd expected %0d actual %0d",
                                 $realtime, pred.ang, got.ang);
                    end
                    if (got.reached !== pred.reached)
                    begin
                        errors++;
                        $display("%0t: goal_reached expected %0b actual %0b",
                                 $realtime, pred.reached, got.reached);
                    end
                end
            end
            if (odo.valid && odo.ready)
            begin
                if (controller_law(pred))
                    expected_cmds.push_back(pred);
            end
        end
    end

endmodule

/* test/unicycle_goal_impedance_controller_test.sv */
module unicycle_goal_impedance_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES       = 6;
    localparam int RANDOM_WORDS = 215;
    localparam int HOLD_CYCLES  = 800;
    localparam int SETTLE       = 300;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          outstanding;
    int          errors;
    bit          no_idle;
    int          hold_requests;

    ugic_odo_if odo ();
    ugic_cmd_if cmd ();

    unicycle_goal_impedance_controller u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .odo     (odo.sink),
        .cmd     (cmd.source)
    );

    ugic_cmd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .odo         (odo),
        .cmd         (cmd),
        .outstanding (outstanding),
        .errors      (errors)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Overall time limit.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Command receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int gap_left;
        int hold_left;
        int holds_seen;
        gap_left = 0;
        hold_left = 0;
        holds_seen = 0;
        cmd.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cmd.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                cmd.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 4) == 0)
            begin
                gap_left = $urandom_range(0, 3);
                cmd.ready <= 1'b0;
            end
            else
                cmd.ready <= 1'b1;
        end
    end

    // Register write over the APB port: setup cycle, then access cycle.
    task automatic write_reg(input ugic_pkg::reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_gains(input logic [15:0] k, input logic [15:0] b,
                                 input logic [15:0] m, input logic [22:0] lin_lim,
                                 input logic [22:0] ang_lim, input logic [31:0] gx,
                                 input logic [31:0] gy, input logic [15:0] hdg);
        write_reg(ugic_pkg::REG_STIFFNESS, {16'd0, k});
        write_reg(ugic_pkg::REG_DAMPING, {16'd0, b});
        write_reg(ugic_pkg::REG_MASS, {16'd0, m});
        write_reg(ugic_pkg::REG_MAX_LIN, {9'd0, lin_lim});
        write_reg(ugic_pkg::REG_MAX_ANG, {9'd0, ang_lim});
        write_reg(ugic_pkg::REG_GOAL_X, gx);
        write_reg(ugic_pkg::REG_GOAL_Y, gy);
        write_reg(ugic_pkg::REG_GOAL_HDG, {16'd0, hdg});
    endtask

    // Offer one odometry word and wait until it is taken, then maybe idle.
    task automatic send_odo(input logic [31:0] px, input logic [31:0] py,
                            input logic [15:0] qz, input logic [15:0] qw,
                            input logic [23:0] v, input logic [23:0] w);
        odo.valid <= 1'b1;
        odo.pos_x <= px;
        odo.pos_y <= py;
        odo.quat_z <= qz;
        odo.quat_w <= qw;
        odo.lin_speed <= v;
        odo.ang_speed <= w;
        @(posedge clk);
        while (!odo.ready) @(posedge clk);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            odo.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Random odometry word; most land near the goal or at moderate range.
    task automatic send_random(input logic signed [31:0] gx, input logic signed [31:0] gy);
        logic [31:0] px, py;
        logic [15:0] qz, qw;
        logic [23:0] v, w;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            px = gx + $signed($urandom_range(0, 8000)) - 4000;
            py = gy + $signed($urandom_range(0, 8000)) - 4000;
        end
        else if (sel < 8)
        begin
            px = gx + $signed($urandom_range(0, 2097152)) - 1048576;
            py = gy + $signed($urandom_range(0, 2097152)) - 1048576;
        end
        else
        begin
            px = $urandom;
            py = $urandom;
        end
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            // Nearly straight ahead, so the heading dead zone is reachable.
            qz = 16'($signed($urandom_range(0, 600)) - 300);
            qw = 16'sd32767;
        end
        else if (sel == 4)
        begin
            qz = '0;
            qw = '0;
        end
        else
        begin
            qz = 16'($urandom);
            qw = 16'($urandom);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            v = 24'($urandom);
            w = 24'($urandom);
        end
        else
        begin
            v = 24'($signed($urandom_range(0, 262144)) - 131072);
            w = 24'($signed($urandom_range(0, 262144)) - 131072);
        end
        send_odo(px, py, qz, qw, v, w);
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic signed [31:0] gx, gy;
        logic [15:0] hdg;
        rst_n = 1'b0;
        no_idle = 1'b0;
        hold_requests = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        odo.valid = 1'b0;
        odo.pos_x = '0;
        odo.pos_y = '0;
        odo.quat_z = '0;
        odo.quat_w = '0;
        odo.lin_speed = '0;
        odo.ang_speed = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings; the first one only primes.
        send_odo(32'd0, 32'd0, 16'd0, 16'd0, 24'd0, 24'd0);
        send_odo(32'd0, 32'd0, 16'd0, 16'h7FFF, 24'd0, 24'd0);
        send_odo(32'd1000, 32'hFFFF_FC18, 16'd100, 16'h7FFF, 24'd5000, 24'hFFEC78);
        send_odo(32'd0, 32'd0, 16'h2000, 16'h7000, 24'd0, 24'd0);
        send_odo(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 16'h0000, 24'h7FFFFF, 24'h800000);
        send_odo(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h0000, 24'h800000, 24'h7FFFFF);
        send_odo(32'hFFFF_0000, 32'd0, 16'h0000, 16'h7FFF, 24'd65536, 24'd0);
        send_odo(32'h0001_0000, 32'd0, 16'h0000, 16'h7FFF, 24'd0, 24'd0);
        send_odo(32'h0001_0000, 32'd10, 16'h8000, 16'h8000, 24'd0, 24'd0);
        send_odo(32'd0, 32'hFFFF_0000, 16'h7FFF, 16'h8000, 24'd0, 24'd0);
        send_odo(32'd0, 32'h0003_0000, 16'h8000, 16'h7FFF, 24'hFFFFFF, 24'h000001);
        send_odo(32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF, 16'h0001, 24'd0, 24'd0);
        send_odo(32'd0, 32'd0, 16'h4000, 16'h4000, 24'd0, 24'd131072);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait (outstanding == 0);
                repeat (SETTLE) @(posedge clk);
                case (ph)
                    1: begin
                        gx = 32'h7FFF_FFFF; gy = 32'h8000_0000; hdg = 16'h7FFF;
                        program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 23'h7FFFFF, 23'h7FFFFF,
                                      gx, gy, hdg);
                    end
                    2: begin
                        gx = '0; gy = '0; hdg = 16'h8000;
                        program_gains(16'd0, 16'd0, 16'd0, 23'd0, 23'd0, gx, gy, hdg);
                    end
                    default: begin
                        gx = $signed($urandom_range(0, 20_000_000)) - 10_000_000;
                        gy = $signed($urandom_range(0, 20_000_000)) - 10_000_000;
                        hdg = (ph == PHASES - 1) ? 16'd0 : 16'($urandom_range(0, 51472) - 25736);
                        program_gains(16'($urandom), 16'($urandom), 16'($urandom),
                                      23'($urandom), 23'($urandom), gx, gy, hdg);
                    end
                endcase
            end
            else
            begin
                gx = '0;
                gy = '0;
            end
            if (ph == 3)
                hold_requests++;
            if (ph == PHASES - 1)
                no_idle = 1'b1;
            for (int n = 0; n < RANDOM_WORDS; n++)
                send_random(gx, gy);
            // Stop offering once the phase is sent so no word is taken twice.
            odo.valid <= 1'b0;
        end

        wait (outstanding == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ugic_pkg.sv
rtl/core/ugic_odo_if.sv
rtl/core/ugic_cmd_if.sv
rtl/core/ugic_cordic.sv
rtl/core/unicycle_goal_impedance_controller.sv
test/ugic_cmd_checker.sv
test/unicycle_goal_impedance_controller_test.sv
